/* rtl/explicit_heat_sweep_average_macros.svh */
// Assertion macros shared by the checker
`ifndef EXPLICIT_HEAT_SWEEP_AVERAGE_MACROS_SVH
`define EXPLICIT_HEAT_SWEEP_AVERAGE_MACROS_SVH

// implication checked on every clock edge outside reset
`define EHSA_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define EHSA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

/* rtl/ehsa_pkg.sv */
`default_nettype none
package ehsa_pkg;
   localparam int POINTS = 64;
   localparam int IDX_W = $clog2(POINTS);
   localparam int CNT_W = $clog2(POINTS + 1);

   typedef struct packed {
      logic signed [31:0] prev_value;
      logic signed [31:0] coef_lower;
      logic signed [31:0] coef_center;
      logic signed [31:0] coef_upper;
      logic signed [31:0] coef_source;
      logic signed [31:0] source_now;
      logic signed [31:0] source_next;
      logic signed [31:0] left_edge;
      logic signed [31:0] right_edge;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_value;
      logic               last_out;
   } rsp_type;
endpackage
`default_nettype wire

/* rtl/explicit_heat_sweep_average.sv */
// One explicit time step of a 1D heat solver (two-sweep scheme), Q16.16.
// Points load one per cycle; the item with last_point set starts the solve.
// Each interior point of each sweep runs on the one shared 32x32
// multiplier (three memory reads, four products accumulated, then a
// saturate and write-back). The output pass then reads each point
// through the registered memory read. Grids of one or two points skip
// the sweeps. req_stall is high throughout the solve. An overflowing
// item past 64 points is dropped (edges of a last one still taken).
`default_nettype none
module explicit_heat_sweep_average (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  ehsa_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output ehsa_pkg::rsp_type   rsp_data,
   input  wire                 csr_write,
   input  wire                 csr_wdata
);
   import ehsa_pkg::*;

   localparam logic [2:0] S_LOAD = 3'd0;
   localparam logic [2:0] S_SWP  = 3'd1;
   localparam logic [2:0] S_EDGE = 3'd2;
   localparam logic [2:0] S_OUT  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   // memories
   logic signed [31:0] up_mem   [POINTS];
   logic signed [31:0] down_mem [POINTS];
   logic [127:0]       coef_mem [POINTS];
   logic [63:0]        src_mem  [POINTS];

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] t_ff, t_in;
   logic             down_ff, down_in;   // 0 upward sweep, 1 downward
   logic [2:0]       ph_ff, ph_in;
   logic             src_en_ff;
   logic signed [31:0] left_ff, right_ff;
   logic signed [31:0] um_ff, u0_ff, up_ff;
   logic [127:0]       c_ff;
   logic [63:0]        s_ff;
   logic signed [31:0] rd_up_ff, rd_dn_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   wire accept = req_valid && !req_stall;
   assign req_stall = (state_ff != S_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // memory read index and read-data selection
   logic [IDX_W-1:0] rd_idx;
   logic signed [31:0] rd_val;
   always_comb begin
      unique case (ph_ff)
         3'd0:    rd_idx = t_ff - 1'b1;
         3'd2:    rd_idx = t_ff + 1'b1;
         default: rd_idx = t_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      rd_up_ff <= up_mem[rd_idx];
      rd_dn_ff <= down_mem[rd_idx];
      c_ff     <= coef_mem[t_ff];
      s_ff     <= src_mem[t_ff];
   end
   assign rd_val = down_ff ? rd_dn_ff : rd_up_ff;

   // shared multiplier operand selection
   logic signed [31:0] ma, mb;
   always_comb begin
      unique case (ph_ff)
         3'd3:    begin ma = c_ff[95:64]; mb = u0_ff; end
         3'd4:    begin ma = c_ff[63:32]; mb = up_ff; end
         3'd5:    begin ma = c_ff[127:96]; mb = um_ff; end
         default: begin
            ma = src_en_ff ? c_ff[31:0] : 32'sd0;
            mb = down_ff ? s_ff[63:32] : s_ff[31:0];
         end
      endcase
   end

   // signed 32x32 product
   logic signed [63:0] mul_full;
   assign mul_full = ma * mb;

   // saturate accumulated sum
   logic signed [63:0] sum_all;
   logic signed [31:0] sat;
   assign sum_all = acc_ff + prod_ff;
   always_comb begin
      if (sum_all > 64'sd2147483647)       sat = 32'sh7fffffff;
      else if (sum_all < -64'sd2147483648) sat = 32'sh80000000;
      else                                  sat = sum_all[31:0];
   end

   logic signed [32:0] avg_sum;
   logic signed [32:0] avg_half;
   assign avg_sum  = {rd_up_ff[31], rd_up_ff} + {rd_dn_ff[31], rd_dn_ff};
   assign avg_half = (avg_sum + {32'd0, avg_sum[32]}) >>> 1;

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      n_in = n_ff;
      t_in = t_ff;
      down_in = down_ff;
      ph_in = ph_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (count_ff < CNT_W'(POINTS)) count_in = count_ff + 1'b1;
               if (req_data.last_point) begin
                  n_in = (count_ff < CNT_W'(POINTS)) ? count_ff + 1'b1 : count_ff;
                  count_in = '0;
                  t_in = IDX_W'(1);
                  down_in = 1'b0;
                  ph_in = 3'd0;
                  state_in = (n_in >= CNT_W'(3)) ? S_SWP : S_EDGE;
               end
            end
         end
         S_SWP: begin
            ph_in = ph_ff + 1'b1;
            if (ph_ff == 3'd7) begin
               ph_in = 3'd0;
               if (!down_ff) begin
                  if ({1'b0, t_ff} + 2'd2 >= n_ff) begin
                     down_in = 1'b1;
                     t_in = IDX_W'(n_ff - 2'd2);
                  end else t_in = t_ff + 1'b1;
               end else begin
                  if (t_ff == IDX_W'(1)) state_in = S_EDGE;
                  else t_in = t_ff - 1'b1;
               end
            end
         end
         S_EDGE: begin
            t_in = '0;
            ph_in = 3'd1;
            state_in = S_OUT;
         end
         S_OUT: state_in = S_EMIT;   // read data registered
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if ({1'b0, t_ff} + 1'b1 == n_ff) state_in = S_LOAD;
               else begin
                  t_in = t_ff + 1'b1;
                  state_in = S_OUT;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         n_ff <= '0;
         t_ff <= '0;
         down_ff <= 1'b0;
         ph_ff <= '0;
         src_en_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         n_ff <= n_in;
         t_ff <= t_in;
         down_ff <= down_in;
         ph_ff <= ph_in;
         if (csr_write) src_en_ff <= csr_wdata;
         if (state_ff == S_EMIT && (!rsp_valid_ff || !rsp_stall)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath: loading, sweep steps, edges, output
   always_ff @(posedge clock) begin
      if (state_ff == S_LOAD && accept) begin
         if (count_ff < CNT_W'(POINTS)) begin
            up_mem[count_ff[IDX_W-1:0]]   <= req_data.prev_value;
            down_mem[count_ff[IDX_W-1:0]] <= req_data.prev_value;
            coef_mem[count_ff[IDX_W-1:0]] <= {req_data.coef_lower, req_data.coef_center,
                                              req_data.coef_upper, req_data.coef_source};
            src_mem[count_ff[IDX_W-1:0]]  <= {req_data.source_now, req_data.source_next};
         end
         left_ff  <= req_data.left_edge;
         right_ff <= req_data.right_edge;
      end
      if (state_ff == S_SWP) begin
         unique case (ph_ff)
            3'd1: um_ff <= rd_val;
            3'd2: u0_ff <= rd_val;
            3'd3: up_ff <= rd_val;
            default: ;
         endcase
         if (ph_ff >= 3'd3) prod_ff <= mul_full >>> 16;
         if (ph_ff >= 3'd4 && ph_ff <= 3'd6) acc_ff <= acc_ff + prod_ff;
         if (ph_ff == 3'd3) acc_ff <= '0;
         if (ph_ff == 3'd7) begin
            if (down_ff) down_mem[t_ff] <= sat;
            else         up_mem[t_ff]   <= sat;
         end
      end
      // with a single point the right edge takes the one entry
      if (state_ff == S_EDGE) begin
         if (n_ff != CNT_W'(1)) begin
            up_mem[0]   <= left_ff;
            down_mem[0] <= left_ff;
         end
         up_mem[IDX_W'(n_ff - 1'b1)]   <= right_ff;
         down_mem[IDX_W'(n_ff - 1'b1)] <= right_ff;
      end
      if (state_ff == S_EMIT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.new_value <= avg_half[31:0];
         rsp_ff.last_out  <= ({1'b0, t_ff} + 1'b1 == n_ff);
      end
   end
endmodule
`default_nettype wire

/* rtl/ehsa_checker.sv */
`default_nettype none
`include "explicit_heat_sweep_average_macros.svh"
module ehsa_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_valid,
   input wire                req_stall,
   input ehsa_pkg::req_type  req_data,
   input wire                rsp_valid,
   input wire                rsp_stall,
   input ehsa_pkg::rsp_type  rsp_data
);
   import ehsa_pkg::*;

   // a last point closes the grid: the block stops taking items
   `EHSA_ASSERT_NEXT(a_last_stalls, clock, reset,
      req_valid && !req_stall && req_data.last_point, req_stall)
   // results other than the last only while solving
   `EHSA_ASSERT_IMPL(a_rsp_busy, clock, reset, rsp_valid && !rsp_stall && !rsp_data.last_out,
      req_stall)
   // a stalled result holds
   `EHSA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))
endmodule

bind explicit_heat_sweep_average ehsa_checker u_ehsa_checker (.*);
`default_nettype wire
